/* src/tcce_pkg.sv */
// Shared types and constants of the text console cursor engine.
`timescale 1ns / 1ps

package tcce_pkg;

   typedef logic [0:0] opcode_type;
   typedef logic [7:0] char_type;
   typedef logic [4:0] row_field_type;
   typedef logic [6:0] col_field_type;

   localparam opcode_type OP_PUT  = 1'b0;
   localparam opcode_type OP_READ = 1'b1;

   localparam char_type CHAR_BACKSPACE = 8'd8;
   localparam char_type CHAR_TAB       = 8'd9;
   localparam char_type CHAR_LF        = 8'd10;
   localparam char_type CHAR_CR        = 8'd13;
   localparam char_type CHAR_BLANK     = 8'h20;
   localparam char_type CHAR_NUL       = 8'h00;

   typedef struct packed {
      logic write;
      logic scroll;
   } step_flags_type;

endpackage

/* src/tcce_req_if.sv */
// Request channel: one put or read command per beat.
`timescale 1ns / 1ps

interface tcce_req_if;
   logic                    valid;
   logic                    ready;
   tcce_pkg::opcode_type    opcode;
   tcce_pkg::char_type      char_code;
   tcce_pkg::row_field_type read_row;
   tcce_pkg::col_field_type read_col;

   modport source (output valid, opcode, char_code, read_row, read_col, input ready);
   modport sink   (input valid, opcode, char_code, read_row, read_col, output ready);
endinterface

/* src/tcce_rsp_if.sv */
// Response channel: cursor position, read cell and scroll flag per beat.
`timescale 1ns / 1ps

interface tcce_rsp_if;
   logic                    valid;
   logic                    ready;
   tcce_pkg::col_field_type cursor_col;
   tcce_pkg::row_field_type cursor_row;
   tcce_pkg::char_type      cell_char;
   logic                    scrolled;

   modport source (output valid, cursor_col, cursor_row, cell_char, scrolled, input ready);
   modport sink   (input valid, cursor_col, cursor_row, cell_char, scrolled, output ready);
endinterface

/* src/text_console_cursor_engine_core.sv */
// Top level of the text console cursor engine: sequencer, cursor and screen memory.
//
//   channel  dir  fields                                      beat
//   req_chan in   opcode, char_code, read_row, read_col       valid & ready
//   rsp_chan out  cursor_col, cursor_row, cell_char, scrolled  valid & ready
//
// After reset the screen memory is cleared one cell per cycle,
// and no request is taken during that pass.
// A put that does not scroll is answered in the cycle after it is accepted.
// A read passes the registered memory read port and the ST_READ state before it is answered.
// A put that scrolls walks ST_SCROLL then ST_FLUSH: one write port shifts every cell up one row.
// Requests are taken only when the sequencer is idle and the response register is free.
`timescale 1ns / 1ps

module text_console_cursor_engine_core #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input logic            clock,
   input logic            reset,
   tcce_req_if.sink       req_chan,
   tcce_rsp_if.source     rsp_chan
);

   localparam int CELLS = ROWS * COLUMNS;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(COLUMNS);
   localparam int RW    = $clog2(ROWS);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_READ   = 3'd2;
   localparam logic [2:0] ST_SCROLL = 3'd3;
   localparam logic [2:0] ST_FLUSH  = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [AW-1:0] sc_ff, sc_in;
   logic [AW-1:0] wa_ff, wa_in;
   logic          pend_ff, pend_in;
   logic          pend_blank_ff, pend_blank_in;
   logic          rd_ok_ff, rd_ok_in;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   tcce_pkg::col_field_type rsp_col_ff, rsp_col_in;
   tcce_pkg::row_field_type rsp_row_ff, rsp_row_in;
   tcce_pkg::char_type      rsp_cell_ff, rsp_cell_in;
   logic                    rsp_scr_ff, rsp_scr_in;

   logic                     ram_we;
   logic [AW-1:0]            ram_wa;
   tcce_pkg::char_type       ram_wd;
   logic                     ram_re;
   logic [AW-1:0]            ram_ra;
   tcce_pkg::char_type       ram_rd;

   logic [CW-1:0]            step_col;
   logic [RW-1:0]            step_row;
   logic [CW-1:0]            step_wcol;
   logic [RW-1:0]            step_wrow;
   tcce_pkg::char_type       step_data;
   tcce_pkg::step_flags_type step_flags;

   logic          accept;
   logic          read_in_range;
   logic [AW-1:0] read_addr;
   logic [AW-1:0] put_addr;

   tcce_cursor_step #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS),
      .CW      (CW),
      .RW      (RW)
   ) u_step (
      .col       (col_ff),
      .row       (row_ff),
      .char_code (req_chan.char_code),
      .next_col  (step_col),
      .next_row  (step_row),
      .wr_col    (step_wcol),
      .wr_row    (step_wrow),
      .wr_data   (step_data),
      .flags     (step_flags)
   );

   tcce_screen_ram #(
      .DEPTH (CELLS),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (ram_re),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   assign req_chan.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign accept         = req_chan.valid && req_chan.ready;

   assign read_in_range = (32'(req_chan.read_row) < ROWS) && (32'(req_chan.read_col) < COLUMNS);
   assign read_addr     = AW'(32'(req_chan.read_row) * COLUMNS + 32'(req_chan.read_col));
   assign put_addr      = AW'(32'(step_wrow) * COLUMNS + 32'(step_wcol));

   always_comb begin
      state_in      = state_ff;
      sc_in         = sc_ff;
      wa_in         = wa_ff;
      pend_in       = 1'b0;
      pend_blank_in = pend_blank_ff;
      rd_ok_in      = rd_ok_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_col_in    = rsp_col_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_cell_in   = rsp_cell_ff;
      rsp_scr_in    = rsp_scr_ff;
      ram_we        = 1'b0;
      ram_wa        = sc_ff;
      ram_wd        = tcce_pkg::CHAR_NUL;
      ram_re        = 1'b0;
      ram_ra        = read_addr;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            ram_wa = sc_ff;
            ram_wd = tcce_pkg::CHAR_NUL;
            if (sc_ff == AW'(CELLS - 1)) begin
               sc_in    = '0;
               state_in = ST_IDLE;
            end else begin
               sc_in = sc_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_chan.opcode == tcce_pkg::OP_READ) begin
                  ram_re   = 1'b1;
                  ram_ra   = read_addr;
                  rd_ok_in = read_in_range;
                  state_in = ST_READ;
               end else begin
                  ram_we = step_flags.write;
                  ram_wa = put_addr;
                  ram_wd = step_data;
                  col_in = step_col;
                  row_in = step_row;
                  if (step_flags.scroll) begin
                     sc_in    = '0;
                     state_in = ST_SCROLL;
                  end else begin
                     rsp_valid_in = 1'b1;
                     rsp_col_in   = tcce_pkg::col_field_type'(step_col);
                     rsp_row_in   = tcce_pkg::row_field_type'(step_row);
                     rsp_cell_in  = tcce_pkg::CHAR_NUL;
                     rsp_scr_in   = 1'b0;
                  end
               end
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_col_in   = tcce_pkg::col_field_type'(col_ff);
            rsp_row_in   = tcce_pkg::row_field_type'(row_ff);
            rsp_cell_in  = rd_ok_ff ? ram_rd : tcce_pkg::CHAR_NUL;
            rsp_scr_in   = 1'b0;
            state_in     = ST_IDLE;
         end
         ST_SCROLL: begin
            pend_in       = 1'b1;
            wa_in         = sc_ff;
            pend_blank_in = (32'(sc_ff) >= CELLS - COLUMNS);
            if (32'(sc_ff) < CELLS - COLUMNS) begin
               ram_re = 1'b1;
               ram_ra = AW'(32'(sc_ff) + COLUMNS);
            end
            if (sc_ff == AW'(CELLS - 1)) begin
               sc_in    = '0;
               state_in = ST_FLUSH;
            end else begin
               sc_in = sc_ff + AW'(1);
            end
         end
         ST_FLUSH: begin
            rsp_valid_in = 1'b1;
            rsp_col_in   = tcce_pkg::col_field_type'(col_ff);
            rsp_row_in   = tcce_pkg::row_field_type'(row_ff);
            rsp_cell_in  = tcce_pkg::CHAR_NUL;
            rsp_scr_in   = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
            sc_in    = '0;
         end
      endcase

      // The copy pipeline writes each cell in the cycle after its source was read.
      if (pend_ff) begin
         ram_we = 1'b1;
         ram_wa = wa_ff;
         ram_wd = pend_blank_ff ? tcce_pkg::CHAR_BLANK : ram_rd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         sc_ff        <= '0;
         pend_ff      <= 1'b0;
         col_ff       <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sc_ff        <= sc_in;
         pend_ff      <= pend_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wa_ff         <= wa_in;
      pend_blank_ff <= pend_blank_in;
      rd_ok_ff      <= rd_ok_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_cell_ff   <= rsp_cell_in;
      rsp_scr_ff    <= rsp_scr_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.cursor_col = rsp_col_ff;
   assign rsp_chan.cursor_row = rsp_row_ff;
   assign rsp_chan.cell_char  = rsp_cell_ff;
   assign rsp_chan.scrolled   = rsp_scr_ff;

endmodule

/* src/tcce_screen_ram.sv */
// Character screen memory with one write port and one registered read port.
`timescale 1ns / 1ps

module tcce_screen_ram #(
   parameter int DEPTH = 2000,
   parameter int AW    = 11
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  tcce_pkg::char_type wr_data,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr,
   output tcce_pkg::char_type rd_data
);

   tcce_pkg::char_type mem [DEPTH];
   tcce_pkg::char_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/tcce_cursor_step.sv */
// Cursor update for one put character: new position, cell write and scroll decision.
`timescale 1ns / 1ps

module tcce_cursor_step #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25,
   parameter int CW      = 7,
   parameter int RW      = 5
) (
   input  logic [CW-1:0]           col,
   input  logic [RW-1:0]           row,
   input  tcce_pkg::char_type      char_code,
   output logic [CW-1:0]           next_col,
   output logic [RW-1:0]           next_row,
   output logic [CW-1:0]           wr_col,
   output logic [RW-1:0]           wr_row,
   output tcce_pkg::char_type      wr_data,
   output tcce_pkg::step_flags_type flags
);

   logic [CW:0] col_x;
   logic [RW:0] row_x;

   always_comb begin
      col_x        = {1'b0, col};
      row_x        = {1'b0, row};
      wr_col       = col;
      wr_row       = row;
      wr_data      = char_code;
      flags.write  = 1'b0;
      flags.scroll = 1'b0;

      case (char_code)
         tcce_pkg::CHAR_BACKSPACE: begin
            if (col != '0) begin
               col_x = col_x - (CW+1)'(1);
            end else if (row != '0) begin
               row_x = row_x - (RW+1)'(1);
               col_x = (CW+1)'(COLUMNS - 1);
            end
            wr_col      = col_x[CW-1:0];
            wr_row      = row_x[RW-1:0];
            wr_data     = tcce_pkg::CHAR_BLANK;
            flags.write = 1'b1;
         end
         tcce_pkg::CHAR_TAB: begin
            col_x = (col_x | (CW+1)'(3)) + (CW+1)'(1);
         end
         tcce_pkg::CHAR_CR: begin
            col_x = '0;
         end
         tcce_pkg::CHAR_LF: begin
            col_x = '0;
            row_x = row_x + (RW+1)'(1);
         end
         default: begin
            flags.write = 1'b1;
            col_x       = col_x + (CW+1)'(1);
         end
      endcase

      if (col_x >= (CW+1)'(COLUMNS)) begin
         col_x = '0;
         row_x = row_x + (RW+1)'(1);
      end
      if (row_x >= (RW+1)'(ROWS)) begin
         row_x        = (RW+1)'(ROWS - 1);
         flags.scroll = 1'b1;
      end

      next_col = col_x[CW-1:0];
      next_row = row_x[RW-1:0];
   end

endmodule
